@@ sv/swm_pkg.sv @@
// Shared types and constants for the sliding window median filter.
`default_nettype none

package swm_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int CFG_W           = 7;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

  // Control bits handed from one cell to the next one up the chain.
  typedef struct packed {
    logic removed;  // oldest entry removed at or below this cell
    logic gt;       // compacted entry here is above the new sample, or the slot is empty
  } swm_link_t;

endpackage

`default_nettype wire

@@ sv/swm_cell.sv @@
// One cell of the sorted window: holds a sample and its age, shifts on insert/remove.
`default_nettype none

module swm_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int AGE_W       = 6
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic                   hold_valid,
  input  logic                   comp_valid,
  input  logic                   full,
  input  logic [AGE_W-1:0]       oldest_age,
  input  logic [SAMPLE_BITS-1:0] new_val,
  input  logic [SAMPLE_BITS-1:0] up_val,
  input  logic [AGE_W-1:0]       up_age,
  input  swm_link_t              left_link,
  input  logic [SAMPLE_BITS-1:0] left_cval,
  input  logic [AGE_W-1:0]       left_cage,
  output swm_link_t              link,
  output logic [SAMPLE_BITS-1:0] cval,
  output logic [AGE_W-1:0]       cage,
  output logic [SAMPLE_BITS-1:0] val,
  output logic [AGE_W-1:0]       age
);

  logic                   rm;
  logic [SAMPLE_BITS-1:0] val_next;
  logic [AGE_W-1:0]       age_next;

  assign rm           = full && hold_valid && (age == oldest_age);
  assign link.removed = left_link.removed || rm;
  assign cval         = link.removed ? up_val : val;
  assign cage         = link.removed ? up_age : age;
  assign link.gt      = !(comp_valid && ($signed(cval) <= $signed(new_val)));

  always_comb begin
    if (link.gt) begin
      if (left_link.gt) begin
        val_next = left_cval;
        age_next = left_cage + AGE_W'(1);
      end else begin
        val_next = new_val;
        age_next = '0;
      end
    end else begin
      val_next = cval;
      age_next = cage + AGE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/swm_out.sv @@
// Median select from the cell row and the output holding register.
`default_nettype none

module swm_out
  import swm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int IDX_W       = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pend,
  input  logic [IDX_W-1:0]       mid,
  input  logic [SAMPLE_BITS-1:0] vals [MAX_WINDOW],
  input  logic                   median_stall,
  output logic                   take,
  output logic                   median_valid,
  output logic [SAMPLE_BITS-1:0] median
);

  assign take = pend && (!median_valid || !median_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
    end else if (take) begin
      median_valid <= 1'b1;
    end else if (!median_stall) begin
      median_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      median <= vals[mid];
    end
  end

endmodule

`default_nettype wire

@@ sv/sliding_window_median_top.sv @@
// Top level of the sliding window median filter.
//
// Input channel: sample with sample_valid / sample_stall. A transaction takes
// one signed sample. Output channel: median with median_valid / median_stall.
// Config channel: window_size with cfg_valid / cfg_ready (always ready); a
// write empties the window. Write it only while the filter is idle.
// Each sample is inserted into a sorted row of cells, the oldest entry leaving
// at the same time. Once the window holds window_size samples (clamped to
// 1..MAX_WINDOW), every sample yields the lower median; earlier yield nothing.
// A sample that yields a median sets a pending flag; the median is then taken
// into the output register. Throughput: one sample per cycle while not stalled.
// When the receiver stalls, the median holds in the output register; one more
// sample is taken and its result waits, then sample_stall rises until the
// output register frees up.
// Reset: window_size returns to 3, the window is empty, no median is pending.
`default_nettype none

module sliding_window_median_top
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   median_valid,
  input  logic                   median_stall,
  output logic [SAMPLE_BITS-1:0] median,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       window_size
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int IDX_W = AGE_W;

  logic [CFG_W-1:0] win_size;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] fill_rem;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] k_m1;
  logic [AGE_W-1:0] oldest_age;
  logic [IDX_W-1:0] mid;
  logic             full;
  logic             emit;
  logic             accept;
  logic             pend;
  logic             take;

  logic [SAMPLE_BITS-1:0] val_q [MAX_WINDOW];
  logic [AGE_W-1:0]       age_q [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] cval  [MAX_WINDOW];
  logic [AGE_W-1:0]       cage  [MAX_WINDOW];
  swm_link_t              link  [MAX_WINDOW];

  always_comb begin
    if (win_size == '0) begin
      k = CNT_W'(1);
    end else if (32'(win_size) > MAX_WINDOW) begin
      k = CNT_W'(MAX_WINDOW);
    end else begin
      k = CNT_W'(win_size);
    end
  end

  assign k_m1       = k - CNT_W'(1);
  assign oldest_age = AGE_W'(k_m1);
  assign mid        = IDX_W'(k_m1 >> 1);
  assign full       = (fill == k);
  assign fill_rem   = full ? fill - CNT_W'(1) : fill;
  assign fill_next  = fill_rem + CNT_W'(1);
  assign emit       = (fill_next == k);

  assign cfg_ready    = 1'b1;
  assign sample_stall = pend && !take;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size <= WINDOW_RESET;
      fill     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      win_size <= window_size;
      fill     <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= emit;
    end else if (take) begin
      pend <= 1'b0;
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic [SAMPLE_BITS-1:0] up_val;
    logic [AGE_W-1:0]       up_age;
    swm_link_t              left_link;
    logic [SAMPLE_BITS-1:0] left_cval;
    logic [AGE_W-1:0]       left_cage;

    if (i + 1 < MAX_WINDOW) begin : g_up
      assign up_val = val_q[i+1];
      assign up_age = age_q[i+1];
    end else begin : g_top
      assign up_val = '0;
      assign up_age = '0;
    end

    if (i > 0) begin : g_left
      assign left_link = link[i-1];
      assign left_cval = cval[i-1];
      assign left_cage = cage[i-1];
    end else begin : g_bottom
      assign left_link = '0;
      assign left_cval = '0;
      assign left_cage = '0;
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_W       (AGE_W)
    ) u_cell (
      .clk        (clk),
      .load       (accept),
      .hold_valid (IDX < fill),
      .comp_valid (IDX < fill_rem),
      .full       (full),
      .oldest_age (oldest_age),
      .new_val    (sample),
      .up_val     (up_val),
      .up_age     (up_age),
      .left_link  (left_link),
      .left_cval  (left_cval),
      .left_cage  (left_cage),
      .link       (link[i]),
      .cval       (cval[i]),
      .cage       (cage[i]),
      .val        (val_q[i]),
      .age        (age_q[i])
    );
  end

  swm_out #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW),
    .IDX_W       (IDX_W)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .pend         (pend),
    .mid          (mid),
    .vals         (val_q),
    .median_stall (median_stall),
    .take         (take),
    .median_valid (median_valid),
    .median       (median)
  );

endmodule

`default_nettype wire

@@ sv/swm_checker.sv @@
// Port-level assertions for the sliding window median filter, bound to the top level.
`default_nettype none

module swm_checker
  import swm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   sample_valid,
  input wire logic                   sample_stall,
  input wire logic                   median_valid,
  input wire logic                   median_stall,
  input wire logic [SAMPLE_BITS-1:0] median
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    median_valid && median_stall |=> median_valid && $stable(median))
    else $error("median changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !median_valid)
    else $error("median valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> median_valid && median_stall)
    else $error("input stalled with output free");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(median_valid) |-> $past(sample_valid && !sample_stall, 2))
    else $error("median without a sample transaction two cycles earlier");

endmodule

bind sliding_window_median_top swm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .median_valid (median_valid),
  .median_stall (median_stall),
  .median       (median)
);

`default_nettype wire
